>>> src/evnsp_pkg.sv
// ----------------------------------------------------------------------------
// Next stop picker package
// Shared widths, call vector layout and outcome codes.
// ----------------------------------------------------------------------------
package evnsp_pkg;

    // Width of a floor number on the ports.
    localparam int FLOOR_W = 5;

    // Width of the pending call vector, three buttons per floor.
    localparam int CALL_BITS = 12;

    // Button positions within the three bits of one floor.
    localparam int BTN_UP   = 0;
    localparam int BTN_DOWN = 1;
    localparam int BTN_CAB  = 2;

    // Result codes.
    typedef enum logic [1:0] {
        OUT_CHOSEN  = 2'd0,
        OUT_NONE    = 2'd1,
        OUT_INVALID = 2'd2
    } t_outcome;

endpackage

>>> src/elevator_next_stop_picker.sv
// ----------------------------------------------------------------------------
// Elevator next stop picker
// Chooses the next floor an elevator car should serve from its current floor,
// its target floor and the vector of pending hall and cab calls.
//
// Usage:
//   The request channel (i_in_valid / o_in_ready) carries the current floor,
//   the target floor, their presence flags and the call vector. The result
//   channel (o_out_valid / i_out_ready) carries the chosen floor and an
//   outcome code: floor chosen, no floor, or invalid floor in the request.
//   Each transaction on the request channel yields exactly one result.
//   A request passes through the stage registers in order before o_out_valid
//   rises. Stage one decodes
//   the request into per-floor candidate masks, stage two runs the priority
//   encoders, stage three selects the result into the output register.
//   Throughput is one transaction per cycle; each stage holds when the stage
//   after it is full and stalled, so a stall at i_out_ready backs up through
//   the pipeline and finally drops o_in_ready, with nothing lost or repeated.
//   Reset clears all stage valid bits; no results are pending after reset.
// ----------------------------------------------------------------------------
module elevator_next_stop_picker #(
    parameter int FLOORS = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [evnsp_pkg::FLOOR_W-1:0] i_current_floor,
    input  logic                         i_has_current,
    input  logic [evnsp_pkg::FLOOR_W-1:0] i_target_floor,
    input  logic                         i_has_target,
    input  logic [evnsp_pkg::CALL_BITS-1:0] i_calls,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [evnsp_pkg::FLOOR_W-1:0] o_next_floor,
    output logic [1:0]                   o_outcome
);
    import evnsp_pkg::*;

    localparam int IDX_W = (FLOORS > 1) ? $clog2(FLOORS) : 1;

    // Stage enables: a stage loads when it is empty or its content moves on.
    logic en1, en2, en3;
    logic r_v1, r_v2, r_v3;

    assign en3 = !r_v3 || i_out_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_in_ready = en1;

    // Per-floor call summaries; floors past the call vector never have calls.
    logic [FLOORS-1:0] w_any;
    logic [FLOORS-1:0] w_real;

    for (genvar f = 0; f < FLOORS; f++) begin : g_floor
        if (3 * f + BTN_CAB < CALL_BITS) begin : g_in
            assign w_any[f] = i_calls[3*f+BTN_UP] | i_calls[3*f+BTN_DOWN]
                            | i_calls[3*f+BTN_CAB];
            assign w_real[f] = (i_calls[3*f+BTN_UP] && (f != FLOORS - 1))
                             | (i_calls[3*f+BTN_DOWN] && (f != 0))
                             | i_calls[3*f+BTN_CAB];
        end else begin : g_out
            assign w_any[f]  = 1'b0;
            assign w_real[f] = 1'b0;
        end
    end

    // Stage one: validity check and scan windows for the directional searches.
    logic              n_invalid1;
    logic [FLOORS-1:0] n_up_mask;
    logic [FLOORS-1:0] n_dn_mask;
    logic              w_idle;
    logic              w_going_up;

    always_comb begin
        logic [FLOOR_W-1:0] fl;
        logic               above_cur;
        n_invalid1 = (i_has_current && (i_current_floor >= FLOOR_W'(FLOORS)))
                   || (i_has_target && (i_target_floor >= FLOOR_W'(FLOORS)));
        w_idle = !i_has_target
               || (i_has_current && (i_current_floor == i_target_floor));
        w_going_up = !i_has_current || (i_current_floor < i_target_floor);
        for (int f = 0; f < FLOORS; f++) begin
            fl = FLOOR_W'(f);
            above_cur = i_has_current ? (fl > i_current_floor) : 1'b1;
            if (w_idle) begin
                n_up_mask[f] = above_cur;
                n_dn_mask[f] = i_has_current ? (fl < i_current_floor) : (fl == '0);
            end else if (w_going_up) begin
                n_up_mask[f] = above_cur && (fl < i_target_floor);
                n_dn_mask[f] = 1'b0;
            end else begin
                n_up_mask[f] = 1'b0;
                n_dn_mask[f] = (fl >= i_target_floor) && (fl < i_current_floor);
            end
        end
    end

    logic               r_invalid1;
    logic               r_has_tgt1;
    logic [FLOOR_W-1:0] r_tgt1;
    logic [FLOORS-1:0]  r_up_cand1;
    logic [FLOORS-1:0]  r_dn_cand1;
    logic [FLOORS-1:0]  r_real1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_invalid1 <= n_invalid1;
            r_has_tgt1 <= i_has_target;
            r_tgt1     <= i_target_floor;
            r_up_cand1 <= w_any & n_up_mask;
            r_dn_cand1 <= w_any & n_dn_mask;
            r_real1    <= w_real;
        end
    end

    // Stage two: priority encoders over the candidate masks.
    logic [IDX_W-1:0] n_up_idx, n_dn_idx, n_real_idx;

    always_comb begin
        n_up_idx   = '0;
        n_real_idx = '0;
        for (int f = FLOORS - 1; f >= 0; f--) begin
            if (r_up_cand1[f]) begin
                n_up_idx = IDX_W'(f);
            end
            if (r_real1[f]) begin
                n_real_idx = IDX_W'(f);
            end
        end
        n_dn_idx = '0;
        for (int f = 0; f < FLOORS; f++) begin
            if (r_dn_cand1[f]) begin
                n_dn_idx = IDX_W'(f);
            end
        end
    end

    logic               r_invalid2;
    logic               r_has_tgt2;
    logic [FLOOR_W-1:0] r_tgt2;
    logic               r_any_real2;
    logic               r_up_found2;
    logic               r_dn_found2;
    logic [IDX_W-1:0]   r_up_idx2;
    logic [IDX_W-1:0]   r_dn_idx2;
    logic [IDX_W-1:0]   r_real_idx2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_invalid2  <= r_invalid1;
            r_has_tgt2  <= r_has_tgt1;
            r_tgt2      <= r_tgt1;
            r_any_real2 <= |r_real1;
            r_up_found2 <= |r_up_cand1;
            r_dn_found2 <= |r_dn_cand1;
            r_up_idx2   <= n_up_idx;
            r_dn_idx2   <= n_dn_idx;
            r_real_idx2 <= n_real_idx;
        end
    end

    // Stage three: pick the result in order of priority.
    logic [FLOOR_W-1:0] n_next;
    t_outcome           n_outcome;

    always_comb begin
        n_next    = '0;
        n_outcome = OUT_NONE;
        if (r_invalid2) begin
            n_outcome = OUT_INVALID;
        end else if (!r_any_real2) begin
            if (r_has_tgt2) begin
                n_next    = r_tgt2;
                n_outcome = OUT_CHOSEN;
            end
        end else if (r_up_found2) begin
            n_next    = FLOOR_W'(r_up_idx2);
            n_outcome = OUT_CHOSEN;
        end else if (r_dn_found2) begin
            n_next    = FLOOR_W'(r_dn_idx2);
            n_outcome = OUT_CHOSEN;
        end else if (r_has_tgt2) begin
            n_next    = r_tgt2;
            n_outcome = OUT_CHOSEN;
        end else begin
            // A real call exists here, so the lowest such floor is taken.
            n_next    = FLOOR_W'(r_real_idx2);
            n_outcome = OUT_CHOSEN;
        end
    end

    logic [FLOOR_W-1:0] r_next3;
    t_outcome           r_outcome3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_next3    <= n_next;
            r_outcome3 <= n_outcome;
        end
    end

    assign o_out_valid  = r_v3;
    assign o_next_floor = r_next3;
    assign o_outcome    = r_outcome3;

endmodule

>>> src/evnsp_checker.sv
// ----------------------------------------------------------------------------
// Next stop picker port checker
// Watches the result channel of the top level and checks its codes.
// ----------------------------------------------------------------------------
module evnsp_checker #(
    parameter int FLOORS = 4
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [evnsp_pkg::FLOOR_W-1:0] o_next_floor,
    input logic [1:0]                    o_outcome
);
    import evnsp_pkg::*;

    // A stalled result holds its valid and its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_next_floor) && $stable(o_outcome)))
        else $error("stalled result changed");

    // Only the three defined codes appear.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_outcome == OUT_CHOSEN || o_outcome == OUT_NONE
                         || o_outcome == OUT_INVALID))
        else $error("undefined outcome code");

    // Without a chosen floor the floor field reads zero.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_outcome != OUT_CHOSEN) |-> (o_next_floor == '0))
        else $error("floor field set without a chosen floor");

    // A chosen floor lies inside the building.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_outcome == OUT_CHOSEN)
            |-> (o_next_floor < FLOOR_W'(FLOORS)))
        else $error("chosen floor out of range");

endmodule

bind elevator_next_stop_picker evnsp_checker #(.FLOORS(FLOORS)) u_evnsp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_next_floor (o_next_floor),
    .o_outcome    (o_outcome)
);
